// File: src/btig_pkg.sv
// shared constants and helpers for the base timer interrupt generator
// used by btig_pend_ctr and base_timer_interrupt_gen_unit, no dependencies
`timescale 1ns / 1ps

package btig_pkg;

  localparam int unsigned NumRates        = 8;
  localparam int unsigned PhaseWidth      = 12;
  localparam int unsigned PendingWidthDef = 16;
  localparam int unsigned CyclesWidthDef  = 16;

  // field widths on the stream ports
  localparam int unsigned ElapsedWidth = 16;
  localparam int unsigned MaskWidth    = 8;
  localparam int unsigned InDataWidth  = 32;
  localparam int unsigned OutDataWidth = 16;

  // divider of rate i is 2**rate_shift(i): 4096, 256, 128, 64, 32, 16, 4, 1
  function automatic int unsigned rate_shift(input int unsigned idx);
    int unsigned sh;
    case (idx)
      0:       sh = 12;
      1:       sh = 8;
      2:       sh = 7;
      3:       sh = 6;
      4:       sh = 5;
      5:       sh = 4;
      6:       sh = 2;
      default: sh = 0;
    endcase
    return sh;
  endfunction

endpackage

// File: src/btig_pend_ctr.sv
// pending crossing counter for one base timer rate
// depends on btig_pkg
`timescale 1ns / 1ps

module btig_pend_ctr #(
  parameter int unsigned Shift        = 0,
  parameter int unsigned SumWidth     = 17,
  parameter int unsigned PendingWidth = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              upd_i,
  input  logic [SumWidth-1:0]               cycles_i,
  input  logic [btig_pkg::PhaseWidth-1:0]   phase_i,
  output logic                              req_o
);
  import btig_pkg::*;

  localparam int unsigned AccWidth = ((SumWidth > PendingWidth) ? SumWidth : PendingWidth) + 1;
  localparam logic [AccWidth-1:0] PendMax = AccWidth'((64'd1 << PendingWidth) - 64'd1);

  logic [PendingWidth-1:0] pend_q, pend_d;
  logic [SumWidth-1:0]     phase_low;
  logic [SumWidth-1:0]     crossed;
  logic [AccWidth-1:0]     acc;

  // boundaries crossed = (phase mod 2**Shift + cycles) >> Shift
  assign phase_low = SumWidth'(phase_i) & ((SumWidth'(1) << Shift) - SumWidth'(1));
  assign crossed   = (cycles_i + phase_low) >> Shift;
  assign acc       = AccWidth'(pend_q) + AccWidth'(crossed);
  assign req_o     = (acc != '0);

  always_comb begin
    if (acc > PendMax) begin
      pend_d = PendingWidth'(PendMax - AccWidth'(1));
    end else if (acc != '0) begin
      pend_d = PendingWidth'(acc - AccWidth'(1));
    end else begin
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (upd_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

// File: src/base_timer_interrupt_gen_unit.sv
// base timer interrupt generator, top level with stream ports
// depends on btig_pkg and btig_pend_ctr
`timescale 1ns / 1ps

// Each input word reports elapsed 8192 Hz crystal cycles, the per-rate enable
// mask and the current request bits; the block advances a 12-bit crystal phase,
// adds the crossed divider boundaries (4096, 256, 128, 64, 32, 16, 4, 1) to
// eight pending counters, takes one pending crossing per nonzero counter as a
// request bit and returns the masked request bits with irq. A zero elapsed
// count leaves the state alone and echoes request_in with irq low. One word is
// taken every cycle while the output is not stalled; a word passes through the
// input register, then through the update logic into the output register, and
// back pressure from the output stalls both stages.
module base_timer_interrupt_gen_unit #(
  parameter int unsigned PendingWidth = btig_pkg::PendingWidthDef,
  parameter int unsigned CyclesWidth  = btig_pkg::CyclesWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // elapsed_cycles[15:0], enable_mask[23:16], request_in[31:24]
  input  logic [btig_pkg::InDataWidth-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // request_out[7:0], irq[8], zero fill [15:9]
  output logic [btig_pkg::OutDataWidth-1:0]     m_axis_tdata
);
  import btig_pkg::*;

  localparam int unsigned SumWidth = ((CyclesWidth > PhaseWidth) ? CyclesWidth : PhaseWidth) + 1;

  logic                    in_valid_q;
  logic [ElapsedWidth-1:0] elapsed_q;
  logic [MaskWidth-1:0]    enable_q;
  logic [MaskWidth-1:0]    req_in_q;
  logic                    out_valid_q;
  logic [MaskWidth-1:0]    req_out_q, req_out_d;
  logic                    irq_q, irq_d;
  logic [PhaseWidth-1:0]   phase_q, phase_d;

  logic                    advance;
  logic                    fire;
  logic                    take;
  logic                    no_cycles;
  logic [CyclesWidth-1:0]  cycles;
  logic [SumWidth-1:0]     cycles_ext;
  logic [NumRates-1:0]     rate_req;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign cycles     = CyclesWidth'(elapsed_q);
  assign cycles_ext = SumWidth'(cycles);
  assign no_cycles  = (cycles == '0);

  for (genvar g = 0; g < NumRates; g++) begin : g_rate
    btig_pend_ctr #(
      .Shift        (rate_shift(g)),
      .SumWidth     (SumWidth),
      .PendingWidth (PendingWidth)
    ) u_pend (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .upd_i    (fire && !no_cycles),
      .cycles_i (cycles_ext),
      .phase_i  (phase_q),
      .req_o    (rate_req[g])
    );
  end

  always_comb begin
    phase_d = phase_q + PhaseWidth'(cycles);
    if (no_cycles) begin
      req_out_d = req_in_q;
      irq_d     = 1'b0;
    end else begin
      req_out_d = (req_in_q | rate_req) & enable_q;
      irq_d     = (req_out_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fire && !no_cycles) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      elapsed_q <= s_axis_tdata[ElapsedWidth-1:0];
      enable_q  <= s_axis_tdata[ElapsedWidth+MaskWidth-1:ElapsedWidth];
      req_in_q  <= s_axis_tdata[ElapsedWidth+2*MaskWidth-1:ElapsedWidth+MaskWidth];
    end
    if (fire) begin
      req_out_q <= req_out_d;
      irq_q     <= irq_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-MaskWidth-1){1'b0}}, irq_q, req_out_q};

`ifndef SYNTHESIS
  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q))
    else $error("crystal phase moved without a word passing");

  a_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && no_cycles) |=> $stable(phase_q))
    else $error("crystal phase moved on zero elapsed cycles");

  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("updated word did not reach the output register");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

  a_irq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && no_cycles) |=> !irq_q)
    else $error("irq raised on zero elapsed cycles");
`endif

endmodule
